// File: src/stbft_pkg.sv
// ----------------------------------------------------------------------------
// stbft_pkg
// Shared types and constants for the sorted table best-fit take unit.
// ----------------------------------------------------------------------------
package stbft_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int VAL_W        = 32;
    localparam int STATUS_W     = 2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_CMP,
        S_TRD,
        S_TGET,
        S_SHUP,
        S_PUT,
        S_SHDN,
        S_OUT
    } t_state;

endpackage

// File: src/stbft_ram.sv
// ----------------------------------------------------------------------------
// stbft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/sorted_table_best_fit_take_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_best_fit_take_unit
// Ascending table of nonzero values: sorted insert, and a take that removes
// the largest value not above the key, else the smallest value held.
//
//  channel | dir | tdata                          | tuser
//  s_axis  | in  | value[31:0]                    | operation
//  m_axis  | out | status, taken_value, remaining | -
//
//  An item runs a binary search, each step a RAM read and then a compare;
//  a take then reads the chosen entry. A shift moves the entries above the
//  position, an insert writes the new value, and the result is output.
//  Zero inserts, full inserts and empty takes go straight to output.
//  s_axis_tready is high only while idle; the result waits in a register
//  until m_axis_tready. Reset is synchronous and empties the table at once.
// ----------------------------------------------------------------------------
module sorted_table_best_fit_take_unit
    import stbft_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CNT_W   = $clog2(CAPACITY + 1),
    localparam int OUT_W   = STATUS_W + VAL_W + CNT_W,
    localparam int TD_W    = ((OUT_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [VAL_W-1:0] s_axis_tdata,  // value
    input  logic             s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [TD_W-1:0]  m_axis_tdata   // status, taken_value, remaining
);

    t_state              r_state, n_state;
    logic                r_op, n_op;
    logic [VAL_W-1:0]    r_key, n_key;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_lo, n_lo;
    logic [CNT_W-1:0]    r_hi, n_hi;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_pos, n_pos;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_waddr, n_waddr;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]    r_taken, n_taken;

    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    idx_up;
    logic                not_above;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;
    logic                in_acc;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign idx_up    = r_idx + CNT_W'(1);
    assign not_above = (ram_rdata <= r_key);

    stbft_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_pend   = r_pend;
        n_waddr  = r_waddr;
        n_status = r_status;
        n_taken  = r_taken;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = s_axis_tuser;
                    n_key    = s_axis_tdata;
                    n_taken  = '0;
                    n_status = ST_OK;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_state  = S_SRCH;
                    if (s_axis_tuser == OP_INSERT) begin
                        if (s_axis_tdata == '0) begin
                            n_status = ST_ZERO;
                            n_state  = S_OUT;
                        end else if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end
                    end else if (r_count == '0) begin
                        n_status = ST_NONE;
                        n_state  = S_OUT;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_CMP;
                end else if (r_op == OP_INSERT) begin
                    n_idx   = r_count;
                    n_pos   = r_lo;
                    n_pend  = 1'b0;
                    n_state = S_SHUP;
                end else begin
                    n_pos   = (r_lo != '0) ? (r_lo - CNT_W'(1)) : '0;
                    n_state = S_TRD;
                end
            end
            S_CMP: begin
                if (not_above) begin
                    n_lo = mid + CNT_W'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = S_SRCH;
            end
            S_TRD: begin
                n_state = S_TGET;
            end
            S_TGET: begin
                n_taken = ram_rdata;
                n_idx   = r_pos;
                n_pend  = 1'b0;
                n_state = S_SHDN;
            end
            S_SHUP: begin
                if (r_idx > r_pos) begin
                    n_pend  = 1'b1;
                    n_waddr = r_idx[AW-1:0];
                    n_idx   = r_idx - CNT_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                n_count = r_count + CNT_W'(1);
                n_state = S_OUT;
            end
            S_SHDN: begin
                if (idx_up < r_count) begin
                    n_pend  = 1'b1;
                    n_waddr = r_idx[AW-1:0];
                    n_idx   = idx_up;
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - CNT_W'(1);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT);
        m_axis_tdata  = TD_W'({r_count, r_taken, r_status});
        ram_we        = 1'b0;
        ram_waddr     = r_waddr;
        ram_wdata     = ram_rdata;
        ram_raddr     = mid[AW-1:0];
        unique case (r_state)
            S_TRD: begin
                ram_raddr = r_pos[AW-1:0];
            end
            S_SHUP: begin
                ram_we    = r_pend;
                ram_raddr = r_idx[AW-1:0] - AW'(1);
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = r_key;
            end
            S_SHDN: begin
                ram_we    = r_pend;
                ram_raddr = idx_up[AW-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_waddr  <= n_waddr;
        r_status <= n_status;
        r_taken  <= n_taken;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH || r_state == S_CMP) |-> !ram_we)
        else $error("RAM write during search");

    a_search_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH || r_state == S_CMP) |-> (r_lo <= r_hi && r_hi <= r_count))
        else $error("search bounds out of order");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == OP_INSERT && s_axis_tdata != '0
         && r_count == CNT_W'(CAPACITY)) |=> (r_status == ST_FULL && r_state == S_OUT))
        else $error("full insert not flagged");

    a_count_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !m_axis_tready) |=> $stable(r_count))
        else $error("count changed while result waits");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_table_best_fit_take_unit. A directed table
// covers the empty, zero, extreme and duplicate cases. Random fill, drain and
// mixed phases follow and push the table to full and back to empty. A local
// sorted-queue predictor tracks every input word and builds the expected result where the table gives none.
// Output words are checked field by field, in order, under random bursts on
// the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb;
    import stbft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W    = $clog2(DEF_CAPACITY + 1);
    localparam int OUT_W    = STATUS_W + VAL_W + CNT_W;
    localparam int TD_W     = ((OUT_W + 7) / 8) * 8;
    localparam int RAND_CNT = 950;
    localparam int DIR_CNT  = 22;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    taken;
        logic [CNT_W-1:0]    remaining;
    } t_fit_result;

    typedef struct {
        logic        op;
        logic [31:0] val;
        bit          typed;
        t_fit_result res;
    } t_dir_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [VAL_W-1:0] s_axis_tdata = '0;  // value
    logic             s_axis_tuser = 1'b0;  // operation
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [TD_W-1:0]  m_axis_tdata;  // status, taken_value, remaining

    logic [VAL_W-1:0] held_values[$];
    t_fit_result      pending_results[$];
    int               error_count = 0;
    int               burst_left = 0;
    int               rx_mode = 0;
    int               rx_left = 0;

    t_dir_row directed_rows [DIR_CNT] = '{
        '{OP_INSERT, 32'h0000_0000, 1'b1, '{ST_ZERO, 32'h0000_0000, 7'd0}},
        '{OP_TAKE,   32'h0000_0000, 1'b1, '{ST_NONE, 32'h0000_0000, 7'd0}},
        '{OP_TAKE,   32'hFFFF_FFFF, 1'b1, '{ST_NONE, 32'h0000_0000, 7'd0}},
        '{OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{ST_OK,   32'h0000_0000, 7'd1}},
        '{OP_INSERT, 32'h0000_0001, 1'b1, '{ST_OK,   32'h0000_0000, 7'd2}},
        '{OP_TAKE,   32'h0000_0000, 1'b1, '{ST_OK,   32'h0000_0001, 7'd1}},
        '{OP_TAKE,   32'hFFFF_FFFE, 1'b1, '{ST_OK,   32'hFFFF_FFFF, 7'd0}},
        '{OP_INSERT, 32'h0000_0005, 1'b1, '{ST_OK,   32'h0000_0000, 7'd1}},
        '{OP_INSERT, 32'h0000_0005, 1'b1, '{ST_OK,   32'h0000_0000, 7'd2}},
        '{OP_INSERT, 32'h0000_0005, 1'b1, '{ST_OK,   32'h0000_0000, 7'd3}},
        '{OP_INSERT, 32'h0000_0000, 1'b1, '{ST_ZERO, 32'h0000_0000, 7'd3}},
        '{OP_TAKE,   32'h0000_0005, 1'b1, '{ST_OK,   32'h0000_0005, 7'd2}},
        '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_INSERT, 32'h5555_5555, 1'b0, '0},
        '{OP_INSERT, 32'h8000_0000, 1'b0, '0},
        '{OP_INSERT, 32'h7FFF_FFFF, 1'b0, '0},
        '{OP_TAKE,   32'h7FFF_FFFE, 1'b0, '0},
        '{OP_TAKE,   32'h0000_0004, 1'b0, '0},
        '{OP_TAKE,   32'hFFFF_FFFF, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0002, 1'b0, '0},
        '{OP_TAKE,   32'h0000_0003, 1'b0, '0},
        '{OP_TAKE,   32'h0000_0000, 1'b0, '0}
    };

    sorted_table_best_fit_take_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // number of held values not above v
    function automatic int count_not_above(logic [VAL_W-1:0] v);
        int n;
        n = 0;
        while (n < held_values.size() && held_values[n] <= v) n++;
        return n;
    endfunction

    function automatic t_fit_result predict_fit(logic op, logic [VAL_W-1:0] v);
        t_fit_result r;
        int          pos;
        r = '0;
        r.status = ST_OK;
        if (op == OP_INSERT) begin
            if (v == '0) begin
                r.status = ST_ZERO;
            end else if (held_values.size() >= DEF_CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                held_values.insert(count_not_above(v), v);
            end
        end else begin
            if (held_values.size() == 0) begin
                r.status = ST_NONE;
            end else begin
                pos = count_not_above(v);
                pos = (pos > 0) ? pos - 1 : 0;
                r.taken = held_values[pos];
                held_values.delete(pos);
            end
        end
        r.remaining = CNT_W'(held_values.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
                                   logic [VAL_W-1:0] want);
        $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_word(logic op, logic [VAL_W-1:0] v, bit typed, t_fit_result typed_res);
        t_fit_result r;
        int          gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(30, 80);
            end else begin
                gap        = $urandom_range(1, 14);
                burst_left = $urandom_range(1, 12);
            end
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        s_axis_tuser  = op;
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_fit(op, v);
        pending_results.push_back(typed ? typed_res : r);
        @(negedge i_clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned sel;
        logic [VAL_W-1:0] v;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            v = '0;
        end else if (sel == 1) begin
            v = '1;
        end else if (sel == 2) begin
            v = 32'd1;
        end else if (sel <= 6) begin
            v = $urandom_range(1, 12);
        end else if (sel <= 10 && held_values.size() > 0) begin
            v = held_values[$urandom_range(0, held_values.size() - 1)]
                + $urandom_range(0, 2) - 1;
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    // output side: ready pattern switches between free, random, sparse and stalled
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready = 1'b1;
            1: m_axis_tready = $urandom_range(0, 1);
            2: m_axis_tready = ($urandom_range(0, 3) == 0);
            default: m_axis_tready = (rx_left % 24 == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_fit_result got;
        t_fit_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status    = m_axis_tdata[STATUS_W-1:0];
            got.taken     = m_axis_tdata[STATUS_W+VAL_W-1:STATUS_W];
            got.remaining = m_axis_tdata[OUT_W-1:STATUS_W+VAL_W];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata[VAL_W-1:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.taken !== want.taken)
                    report_mismatch("taken_value", got.taken, want.taken);
                if (got.remaining !== want.remaining)
                    report_mismatch("remaining", got.remaining, want.remaining);
            end
        end
    end

    initial begin
        int          issued;
        int          phase_len;
        int unsigned insert_pct;
        logic        op;
        logic [VAL_W-1:0] v;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (directed_rows[k])
            send_word(directed_rows[k].op, directed_rows[k].val,
                      directed_rows[k].typed, directed_rows[k].res);
        issued = 0;
        while (issued < RAND_CNT) begin
            case ($urandom_range(0, 2))
                0: insert_pct = 95;
                1: insert_pct = 8;
                default: insert_pct = 50;
            endcase
            phase_len = $urandom_range(50, 120);
            if (phase_len > RAND_CNT - issued) phase_len = RAND_CNT - issued;
            repeat (phase_len) begin
                op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_TAKE;
                v  = pick_value();
                send_word(op, v, 1'b0, '0);
                issued++;
            end
        end
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb failed");
        $finish;
    end

endmodule
